// File: rtl/core/plfr_pkg.sv
`default_nettype none

package plfr_pkg;

  // Square geometry and alphabet size.
  localparam int unsigned NUM_CELLS   = 25;
  localparam int unsigned NUM_LETTERS = 26;

  // Letters with a special role.
  localparam logic [4:0] LET_I = 5'd8;
  localparam logic [4:0] LET_J = 5'd9;
  localparam logic [4:0] LET_X = 5'd23;
  localparam logic [4:0] LET_Z = 5'd25;

  // Request codes.
  localparam logic [1:0] REQ_KEY     = 2'd0;
  localparam logic [1:0] REQ_KEY_END = 2'd1;
  localparam logic [1:0] REQ_MSG     = 2'd2;
  localparam logic [1:0] REQ_MSG_END = 2'd3;

  // Input word.
  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] letter;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic [4:0] cipher_first;
    logic [4:0] cipher_second;
    logic       filler_added;
  } out_word_t;

  // Memory write port.
  typedef struct packed {
    logic       en;
    logic [4:0] addr;
    logic [4:0] data;
  } mem_wr_t;

  // Dual memory read request.
  typedef struct packed {
    logic       en;
    logic [4:0] addr_a;
    logic [4:0] addr_b;
  } mem_rd_t;

  // Row and column of a cell.
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } cell_rc_t;

  // Split a cell index 0..24 into row and column.
  function automatic cell_rc_t cell_to_rc(logic [4:0] cell_idx);
    cell_rc_t rc;
    if (cell_idx >= 5'd20) begin
      rc.row = 3'd4;
      rc.col = 3'(cell_idx - 5'd20);
    end else if (cell_idx >= 5'd15) begin
      rc.row = 3'd3;
      rc.col = 3'(cell_idx - 5'd15);
    end else if (cell_idx >= 5'd10) begin
      rc.row = 3'd2;
      rc.col = 3'(cell_idx - 5'd10);
    end else if (cell_idx >= 5'd5) begin
      rc.row = 3'd1;
      rc.col = 3'(cell_idx - 5'd5);
    end else begin
      rc.row = 3'd0;
      rc.col = 3'(cell_idx);
    end
    return rc;
  endfunction

  // Cell index from row and column: row * 5 + col.
  function automatic logic [4:0] rc_to_cell(logic [2:0] row, logic [2:0] col);
    return {row, 2'b00} + 5'(row) + 5'(col);
  endfunction

  // Step one place along a row or column, wrapping at the edge.
  function automatic logic [2:0] wrap_next(logic [2:0] v);
    return (v == 3'd4) ? 3'd0 : v + 3'd1;
  endfunction

  // Letter in a cell of the default square (alphabet without j).
  function automatic logic [4:0] default_square(logic [4:0] cell_idx);
    return (cell_idx <= LET_I) ? cell_idx : cell_idx + 5'd1;
  endfunction

  // Cell of a letter in the default square; j shares the cell of i.
  function automatic logic [4:0] default_position(logic [4:0] letter);
    return (letter <= LET_I) ? letter : letter - 5'd1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/playfair_digraph_encryptor.sv
// Key letters, and message letters that only open a pair, are taken without leaving idle.
// Completed pair: position read, then square read, then the result waits for the
// output register to be free; the next word is taken once it is loaded. Key end, or
// the first message word after an open key: fill walk of the letter counter first.
// Reset clears control state; the square reads as the alphabet without j until a
// key letter arrives, with no clearing pass.
`default_nettype none

module playfair_digraph_encryptor (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire plfr_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output plfr_pkg::out_word_t      out_word_o
);

  logic                out_valid_q;
  plfr_pkg::out_word_t out_word_q;
  logic                out_free;
  logic                out_load;
  plfr_pkg::out_word_t out_word_new;
  logic                loaded;
  plfr_pkg::mem_wr_t   sq_wr, pos_wr;
  plfr_pkg::mem_rd_t   sq_rd, pos_rd;
  logic [4:0]          sq_a, sq_b, pos_a, pos_b;

  assign out_free = !out_valid_q || out_ready_i;

  plfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .out_word_o (out_word_new),
    .loaded_o   (loaded),
    .sq_wr_o    (sq_wr),
    .sq_rd_o    (sq_rd),
    .sq_a_i     (sq_a),
    .sq_b_i     (sq_b),
    .pos_wr_o   (pos_wr),
    .pos_rd_o   (pos_rd),
    .pos_a_i    (pos_a),
    .pos_b_i    (pos_b)
  );

  plfr_square_mem u_square (
    .clk_i    (clk_i),
    .loaded_i (loaded),
    .wr_i     (sq_wr),
    .rd_i     (sq_rd),
    .rd_a_o   (sq_a),
    .rd_b_o   (sq_b)
  );

  plfr_pos_mem u_pos (
    .clk_i    (clk_i),
    .loaded_i (loaded),
    .wr_i     (pos_wr),
    .rd_i     (pos_rd),
    .rd_a_o   (pos_a),
    .rd_b_o   (pos_b)
  );

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= out_word_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// File: rtl/core/plfr_square_mem.sv
`default_nettype none

// Key square: cell index to letter, one write and two reads per cycle.
module plfr_square_mem (
  input  wire logic              clk_i,
  input  wire logic              loaded_i,
  input  wire plfr_pkg::mem_wr_t wr_i,
  input  wire plfr_pkg::mem_rd_t rd_i,
  output logic [4:0]             rd_a_o,
  output logic [4:0]             rd_b_o
);

  logic [4:0] mem_q [plfr_pkg::NUM_CELLS];
  logic [4:0] rd_a_q, rd_b_q;
  logic [4:0] addr_a_q, addr_b_q;

  // Write port and registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_a_q   <= mem_q[rd_i.addr_a];
      rd_b_q   <= mem_q[rd_i.addr_b];
      addr_a_q <= rd_i.addr_a;
      addr_b_q <= rd_i.addr_b;
    end
  end

  // Until a key has been loaded, the square reads as the default alphabet.
  assign rd_a_o = loaded_i ? rd_a_q : plfr_pkg::default_square(addr_a_q);
  assign rd_b_o = loaded_i ? rd_b_q : plfr_pkg::default_square(addr_b_q);

endmodule

`default_nettype wire

// File: rtl/core/plfr_pos_mem.sv
`default_nettype none

// Letter position table: letter to cell index, one write and two reads per cycle.
module plfr_pos_mem (
  input  wire logic              clk_i,
  input  wire logic              loaded_i,
  input  wire plfr_pkg::mem_wr_t wr_i,
  input  wire plfr_pkg::mem_rd_t rd_i,
  output logic [4:0]             rd_a_o,
  output logic [4:0]             rd_b_o
);

  logic [4:0] mem_q [plfr_pkg::NUM_LETTERS];
  logic [4:0] rd_a_q, rd_b_q;
  logic [4:0] addr_a_q, addr_b_q;

  // Write port and registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_a_q   <= mem_q[rd_i.addr_a];
      rd_b_q   <= mem_q[rd_i.addr_b];
      addr_a_q <= rd_i.addr_a;
      addr_b_q <= rd_i.addr_b;
    end
  end

  // Until a key has been loaded, positions follow the default square.
  assign rd_a_o = loaded_i ? rd_a_q : plfr_pkg::default_position(addr_a_q);
  assign rd_b_o = loaded_i ? rd_b_q : plfr_pkg::default_position(addr_b_q);

endmodule

`default_nettype wire

// File: rtl/core/plfr_ctrl.sv
`default_nettype none

// Sequencer: key loading, key fill walk, pairing and the two-step table lookup.
module plfr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire plfr_pkg::in_word_t  in_word_i,
  input  wire logic                out_free_i,
  output logic                     out_load_o,
  output plfr_pkg::out_word_t      out_word_o,
  output logic                     loaded_o,
  output plfr_pkg::mem_wr_t        sq_wr_o,
  output plfr_pkg::mem_rd_t        sq_rd_o,
  input  wire logic [4:0]          sq_a_i,
  input  wire logic [4:0]          sq_b_i,
  output plfr_pkg::mem_wr_t        pos_wr_o,
  output plfr_pkg::mem_rd_t        pos_rd_o,
  input  wire logic [4:0]          pos_a_i,
  input  wire logic [4:0]          pos_b_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_MSG  = 3'd2;
  localparam logic [2:0] ST_SQRD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic        key_open_q, key_open_d;
  logic        loaded_q, loaded_d;
  logic [25:0] used_q, used_d;
  logic [4:0]  filled_q, filled_d;
  logic        pend_valid_q, pend_valid_d;
  logic [4:0]  pend_letter_q, pend_letter_d;
  logic [1:0]  req_q, req_d;
  logic [4:0]  letter_q, letter_d;
  logic [4:0]  fill_ctr_q, fill_ctr_d;
  logic        filler_q, filler_d;

  logic        accept;
  logic [4:0]  letter_in;
  logic        key_accept;
  logic        msg_go;
  logic [1:0]  msg_req;
  logic [4:0]  msg_letter;
  logic        pair_go;
  logic [4:0]  pair_b;
  logic        pair_filler;
  logic        wr_en;
  logic [4:0]  wr_letter;
  logic [25:0] used_base;
  logic [4:0]  filled_base;
  logic [31:0] used_ext;
  logic [31:0] used_set;
  plfr_pkg::cell_rc_t rc_a, rc_b;
  plfr_pkg::cell_rc_t tgt_a, tgt_b;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign letter_in  = (in_word_i.letter == plfr_pkg::LET_J) ? plfr_pkg::LET_I
                                                            : in_word_i.letter;
  assign key_accept = accept && (in_word_i.req_type == plfr_pkg::REQ_KEY);
  assign loaded_o   = loaded_q;

  // Message handling runs straight from the input when the key is closed,
  // or from the held word once the fill walk is done.
  assign msg_go     = (state_q == ST_MSG) ||
                      (accept && in_word_i.req_type[1] && !key_open_q);
  assign msg_req    = (state_q == ST_MSG) ? req_q : in_word_i.req_type;
  assign msg_letter = (state_q == ST_MSG) ? letter_q : letter_in;

  // Placement of one letter into the next free cell, by key letter or fill walk.
  always_comb begin
    used_base   = used_q;
    filled_base = filled_q;
    wr_letter   = letter_in;
    wr_en       = 1'b0;
    if (key_accept && !key_open_q) begin
      used_base   = '0;
      filled_base = '0;
    end
    used_ext = {6'b0, used_base};
    if (key_accept) begin
      wr_en = (letter_in < 5'(plfr_pkg::NUM_LETTERS)) && !used_ext[letter_in] &&
              (filled_base < 5'(plfr_pkg::NUM_CELLS));
    end else if (state_q == ST_FILL) begin
      wr_letter = fill_ctr_q;
      wr_en     = (fill_ctr_q != plfr_pkg::LET_J) && !used_ext[fill_ctr_q] &&
                  (filled_base < 5'(plfr_pkg::NUM_CELLS));
    end
    used_set = used_ext | (32'(wr_en) << wr_letter);
  end

  assign sq_wr_o  = '{en: wr_en, addr: filled_base, data: wr_letter};
  assign pos_wr_o = '{en: wr_en, addr: wr_letter, data: filled_base};

  // Pairing decision.
  always_comb begin
    pair_go       = 1'b0;
    pair_b        = plfr_pkg::LET_X;
    pair_filler   = 1'b1;
    pend_valid_d  = pend_valid_q;
    pend_letter_d = pend_letter_q;
    if (key_accept && !key_open_q) begin
      pend_valid_d  = 1'b0;
      pend_letter_d = '0;
    end else if (msg_go) begin
      if (msg_req == plfr_pkg::REQ_MSG) begin
        if (msg_letter < 5'(plfr_pkg::NUM_LETTERS)) begin
          if (!pend_valid_q) begin
            pend_valid_d  = 1'b1;
            pend_letter_d = msg_letter;
          end else if (pend_letter_q == msg_letter) begin
            pair_go = 1'b1;
          end else begin
            pair_go       = 1'b1;
            pair_b        = msg_letter;
            pair_filler   = 1'b0;
            pend_valid_d  = 1'b0;
            pend_letter_d = '0;
          end
        end
      end else if (pend_valid_q) begin
        pair_go       = 1'b1;
        pend_valid_d  = 1'b0;
        pend_letter_d = '0;
      end
    end
  end

  assign pos_rd_o = '{en: pair_go, addr_a: pend_letter_q, addr_b: pair_b};

  // Cipher rule on the two positions just read.
  always_comb begin
    rc_a = plfr_pkg::cell_to_rc(pos_a_i);
    rc_b = plfr_pkg::cell_to_rc(pos_b_i);
    if (rc_a.row == rc_b.row) begin
      tgt_a = '{row: rc_a.row, col: plfr_pkg::wrap_next(rc_a.col)};
      tgt_b = '{row: rc_b.row, col: plfr_pkg::wrap_next(rc_b.col)};
    end else if (rc_a.col == rc_b.col) begin
      tgt_a = '{row: plfr_pkg::wrap_next(rc_a.row), col: rc_a.col};
      tgt_b = '{row: plfr_pkg::wrap_next(rc_b.row), col: rc_b.col};
    end else begin
      tgt_a = '{row: rc_b.row, col: rc_a.col};
      tgt_b = '{row: rc_a.row, col: rc_b.col};
    end
  end

  assign sq_rd_o = '{en:     (state_q == ST_SQRD),
                     addr_a: plfr_pkg::rc_to_cell(tgt_a.row, tgt_a.col),
                     addr_b: plfr_pkg::rc_to_cell(tgt_b.row, tgt_b.col)};

  assign out_load_o = (state_q == ST_OUT) && out_free_i;
  assign out_word_o = '{cipher_first: sq_a_i, cipher_second: sq_b_i,
                        filler_added: filler_q};

  // Next state and register updates.
  always_comb begin
    state_d    = state_q;
    key_open_d = key_open_q;
    loaded_d   = loaded_q;
    used_d     = used_set[25:0];
    filled_d   = filled_base + 5'(wr_en);
    req_d      = req_q;
    letter_d   = letter_q;
    fill_ctr_d = fill_ctr_q;
    filler_d   = pair_go ? pair_filler : filler_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d    = in_word_i.req_type;
          letter_d = letter_in;
          unique case (in_word_i.req_type)
            plfr_pkg::REQ_KEY: begin
              key_open_d = 1'b1;
              loaded_d   = 1'b1;
            end
            plfr_pkg::REQ_KEY_END: begin
              if (key_open_q) begin
                fill_ctr_d = '0;
                state_d    = ST_FILL;
              end
            end
            plfr_pkg::REQ_MSG, plfr_pkg::REQ_MSG_END: begin
              if (key_open_q) begin
                fill_ctr_d = '0;
                state_d    = ST_FILL;
              end else if (pair_go) begin
                state_d = ST_SQRD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        if (fill_ctr_q == plfr_pkg::LET_Z) begin
          key_open_d = 1'b0;
          state_d    = (req_q == plfr_pkg::REQ_KEY_END) ? ST_IDLE : ST_MSG;
        end else begin
          fill_ctr_d = fill_ctr_q + 5'd1;
        end
      end
      ST_MSG: begin
        state_d = pair_go ? ST_SQRD : ST_IDLE;
      end
      ST_SQRD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      key_open_q   <= 1'b0;
      loaded_q     <= 1'b0;
      used_q       <= 26'h3FF_FDFF;
      filled_q     <= 5'(plfr_pkg::NUM_CELLS);
      pend_valid_q <= 1'b0;
      pend_letter_q <= '0;
    end else begin
      state_q      <= state_d;
      key_open_q   <= key_open_d;
      loaded_q     <= loaded_d;
      used_q       <= used_d;
      filled_q     <= filled_d;
      pend_valid_q <= pend_valid_d;
      pend_letter_q <= pend_letter_d;
    end
  end

  // Held request word, walk counter and filler flag.
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    letter_q   <= letter_d;
    fill_ctr_q <= fill_ctr_d;
    filler_q   <= filler_d;
  end

endmodule

`default_nettype wire

// File: rtl/core/plfr_checker.sv
`default_nettype none

module plfr_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire plfr_pkg::in_word_t  in_word_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire plfr_pkg::out_word_t out_word_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // Cipher letters are real letters and never j.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.cipher_first < 5'd26 &&
                    out_word_o.cipher_second < 5'd26 &&
                    out_word_o.cipher_first != plfr_pkg::LET_J &&
                    out_word_o.cipher_second != plfr_pkg::LET_J)
    else $error("cipher letter out of range");

  // Two distinct plaintext letters always give two distinct cipher letters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.filler_added |->
      out_word_o.cipher_first != out_word_o.cipher_second)
    else $error("distinct pair gave equal cipher letters");

  // A new result appears only when the input side was not ready just before it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while input side was ready");

  // A key letter never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.req_type == plfr_pkg::REQ_KEY
      |=> !$rose(out_valid_o))
    else $error("key letter produced a result");

endmodule

bind playfair_digraph_encryptor plfr_checker u_plfr_checker (.*);

`default_nettype wire
